>>> src/lcdc_pkg.sv
package lcdc_pkg;

  localparam int RAM_DEPTH  = 4096;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);
  localparam int BANK_DEPTH = RAM_DEPTH / 2;
  localparam int BANK_AW    = ADDR_W - 1;

  localparam logic [7:0] CONTRAST_RESET = 8'd20;

  // command byte codes
  localparam logic [7:0] CMD_COL_LO_FIRST  = 8'h00;
  localparam logic [7:0] CMD_COL_LO_LAST   = 8'h0F;
  localparam logic [7:0] CMD_COL_HI_FIRST  = 8'h10;
  localparam logic [7:0] CMD_COL_HI_LAST   = 8'h17;
  localparam logic [7:0] CMD_SCROLL_FIRST  = 8'h40;
  localparam logic [7:0] CMD_SCROLL_LAST   = 8'h43;
  localparam logic [7:0] CMD_PAGE_FIRST    = 8'hB0;
  localparam logic [7:0] CMD_PAGE_LAST     = 8'hBF;
  localparam logic [7:0] CMD_CONTRAST      = 8'h81;
  localparam logic [7:0] CMD_SAVE_ON       = 8'hA9;
  localparam logic [7:0] CMD_SAVE_OFF      = 8'hE1;
  localparam logic [7:0] CMD_SOFT_RESET    = 8'hE2;

  // display RAM access: even bank holds the first byte of a column, odd the second
  typedef struct packed {
    logic               we;
    logic               we_bank;
    logic [BANK_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [BANK_AW-1:0] raddr;
  } gram_req_t;

  // snapshot of control state taken with a pixel fetch
  typedef struct packed {
    logic       in_view;
    logic       blanked;
    logic [7:0] contrast;
    logic [2:0] bit_sel;
  } fetch_info_t;

endpackage

>>> src/lcd_command_data_gram_controller_top.sv
// channel | dir | tdata (low bit up)                              | tuser
// s_axis  | in  | serial_byte 8, pixel_x 7, pixel_y 6, pad 3      | cmd, data_select
// m_axis  | out | pixel_index 2, contrast_delta 9, power_save 1, pad 4 | -
//
// One word per cycle in steady flow; a pixel fetch shows on m_axis after the display
// RAM read register and the output register.
// Transfers give no output word. Display RAM is two 2048 x 8 banks (even and
// odd byte of a column) so a fetch reads both bytes in one access.
// After rst the RAM is zeroed with s_axis_tready held low.
// A stalled m_axis holds one word in the output and one in the read stage; outside
// the RAM clear s_axis_tready drops only when both are full.
module lcd_command_data_gram_controller_top
  import lcdc_pkg::*;
#(
  parameter int COLS_PER_PAGE = 128,
  parameter int VIEW_WIDTH    = 96,
  parameter int VIEW_HEIGHT   = 64
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // serial_byte, pixel_x, pixel_y, zero pad
  input  logic [1:0]  s_axis_tuser,  // cmd, data_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // pixel_index, contrast_delta, power_save, zero pad
);

  logic        accept;
  logic        xfer;
  logic        fetch;
  logic        busy;
  logic        can_take;
  gram_req_t   req;
  fetch_info_t info;
  logic [7:0]  rd_even;
  logic [7:0]  rd_odd;
  logic [1:0]  pixel_index;
  logic [8:0]  contrast_delta;
  logic        power_save;

  assign s_axis_tready = !busy && can_take;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign xfer          = accept && !s_axis_tuser[0];
  assign fetch         = accept && s_axis_tuser[0];

  lcdc_ctrl #(
    .COLS_PER_PAGE (COLS_PER_PAGE),
    .VIEW_WIDTH    (VIEW_WIDTH),
    .VIEW_HEIGHT   (VIEW_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .xfer        (xfer),
    .fetch       (fetch),
    .data_select (s_axis_tuser[1]),
    .serial_byte (s_axis_tdata[7:0]),
    .pixel_x     (s_axis_tdata[14:8]),
    .pixel_y     (s_axis_tdata[20:15]),
    .req         (req),
    .info        (info)
  );

  lcdc_gram u_gram (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_even (rd_even),
    .rd_odd  (rd_odd),
    .busy    (busy)
  );

  lcdc_out u_out (
    .clk            (clk),
    .rst            (rst),
    .fetch          (fetch),
    .info           (info),
    .rd_even        (rd_even),
    .rd_odd         (rd_odd),
    .can_take       (can_take),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .pixel_index    (pixel_index),
    .contrast_delta (contrast_delta),
    .power_save     (power_save)
  );

  assign m_axis_tdata = {4'b0000, power_save, contrast_delta, pixel_index};

endmodule

>>> src/lcdc_gram.sv
module lcdc_gram
  import lcdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  gram_req_t  req,
  output logic [7:0] rd_even,
  output logic [7:0] rd_odd,
  output logic       busy
);

  logic [7:0] bank_even [BANK_DEPTH];
  logic [7:0] bank_odd  [BANK_DEPTH];

  logic               clearing;
  logic [BANK_AW-1:0] clr_addr;

  // zero sweep after reset, one row of both banks per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == BANK_AW'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      bank_even[clr_addr] <= 8'h00;
      bank_odd[clr_addr]  <= 8'h00;
    end else if (req.we) begin
      if (req.we_bank) begin
        bank_odd[req.waddr] <= req.wdata;
      end else begin
        bank_even[req.waddr] <= req.wdata;
      end
    end
  end

  // read data only moves on a read so a stalled fetch keeps its bytes
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_even <= bank_even[req.raddr];
      rd_odd  <= bank_odd[req.raddr];
    end
  end

  assign busy = clearing;

endmodule

>>> src/lcdc_ctrl.sv
module lcdc_ctrl
  import lcdc_pkg::*;
#(
  parameter int COLS_PER_PAGE = 128,
  parameter int VIEW_WIDTH    = 96,
  parameter int VIEW_HEIGHT   = 64
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        xfer,
  input  logic        fetch,
  input  logic        data_select,
  input  logic [7:0]  serial_byte,
  input  logic [6:0]  pixel_x,
  input  logic [5:0]  pixel_y,
  output gram_req_t   req,
  output fetch_info_t info
);

  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'((2 * COLS_PER_PAGE) % RAM_DEPTH);

  localparam logic [1:0] PH_WAIT     = 2'd0;
  localparam logic [1:0] PH_CONTRAST = 2'd1;
  localparam logic [1:0] PH_SCROLL   = 2'd2;

  logic [7:0] column_ptr, column_ptr_next;
  logic       byte_half, byte_half_next;
  logic [3:0] page_ptr, page_ptr_next;
  logic [7:0] contrast, contrast_next;
  logic [4:0] scroll, scroll_next;
  logic       blanked, blanked_next;
  logic [1:0] phase, phase_next;

  logic [ADDR_W-1:0] wr_addr;
  logic [5:0]        rd_page;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    column_ptr_next = column_ptr;
    byte_half_next  = byte_half;
    page_ptr_next   = page_ptr;
    contrast_next   = contrast;
    scroll_next     = scroll;
    blanked_next    = blanked;
    phase_next      = phase;
    if (xfer) begin
      if (data_select) begin
        if (byte_half) begin
          column_ptr_next = column_ptr + 8'd1;
        end
        byte_half_next = ~byte_half;
      end else if (phase == PH_CONTRAST) begin
        contrast_next = serial_byte;
        phase_next    = PH_WAIT;
      end else if (phase == PH_SCROLL) begin
        scroll_next = serial_byte[7:3];
        phase_next  = PH_WAIT;
      end else begin
        phase_next = PH_WAIT;
        unique case (serial_byte) inside
          [CMD_COL_LO_FIRST:CMD_COL_LO_LAST]: begin
            column_ptr_next = {column_ptr[7:4], serial_byte[3:0]};
            byte_half_next  = 1'b0;
          end
          [CMD_COL_HI_FIRST:CMD_COL_HI_LAST]: begin
            column_ptr_next = {1'b0, serial_byte[2:0], column_ptr[3:0]};
            byte_half_next  = 1'b0;
          end
          [CMD_SCROLL_FIRST:CMD_SCROLL_LAST]: begin
            phase_next = PH_SCROLL;
          end
          [CMD_PAGE_FIRST:CMD_PAGE_LAST]: begin
            page_ptr_next = serial_byte[3:0];
          end
          CMD_CONTRAST: begin
            phase_next = PH_CONTRAST;
          end
          CMD_SAVE_ON: begin
            blanked_next = 1'b1;
          end
          CMD_SAVE_OFF: begin
            blanked_next = 1'b0;
          end
          CMD_SOFT_RESET: begin
            column_ptr_next = '0;
            byte_half_next  = 1'b0;
            page_ptr_next   = '0;
            contrast_next   = CONTRAST_RESET;
            scroll_next     = '0;
            blanked_next    = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_ptr <= '0;
      byte_half  <= 1'b0;
      page_ptr   <= '0;
      contrast   <= CONTRAST_RESET;
      scroll     <= '0;
      blanked    <= 1'b0;
      phase      <= PH_WAIT;
    end else begin
      column_ptr <= column_ptr_next;
      byte_half  <= byte_half_next;
      page_ptr   <= page_ptr_next;
      contrast   <= contrast_next;
      scroll     <= scroll_next;
      blanked    <= blanked_next;
      phase      <= phase_next;
    end
  end

  // column pair base is always even: bit 0 of the address is the bank
  assign wr_addr = ADDR_W'(ADDR_W'(page_ptr) * ROW_STRIDE) + ADDR_W'({column_ptr, 1'b0});
  assign rd_page = 6'(pixel_y[5:3]) + 6'(scroll);
  assign rd_addr = ADDR_W'(ADDR_W'(rd_page) * ROW_STRIDE) + ADDR_W'({pixel_x, 1'b0});

  always_comb begin
    req.we      = xfer & data_select;
    req.we_bank = byte_half;
    req.waddr   = wr_addr[ADDR_W-1:1];
    req.wdata   = serial_byte;
    req.re      = fetch;
    req.raddr   = rd_addr[ADDR_W-1:1];
  end

  always_comb begin
    info.in_view  = (int'(pixel_x) < VIEW_WIDTH) && (int'(pixel_y) < VIEW_HEIGHT);
    info.blanked  = blanked;
    info.contrast = contrast;
    info.bit_sel  = pixel_y[2:0];
  end

endmodule

>>> src/lcdc_out.sv
module lcdc_out
  import lcdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fetch,
  input  fetch_info_t info,
  input  logic [7:0]  rd_even,
  input  logic [7:0]  rd_odd,
  output logic        can_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  pixel_index,
  output logic [8:0]  contrast_delta,
  output logic        power_save
);

  logic        s1_valid;
  fetch_info_t s1_info;
  logic        s1_adv;
  logic [1:0]  s1_index;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign can_take = !s1_valid || s1_adv;

  always_comb begin
    if (s1_info.blanked || !s1_info.in_view) begin
      s1_index = 2'b00;
    end else begin
      s1_index = {rd_even[s1_info.bit_sel], rd_odd[s1_info.bit_sel]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fetch) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch) begin
      s1_info <= info;
    end
    if (s1_adv) begin
      pixel_index    <= s1_index;
      contrast_delta <= {1'b0, s1_info.contrast} - {1'b0, CONTRAST_RESET};
      power_save     <= s1_info.blanked;
    end
  end

endmodule

>>> src/lcdc_checker.sv
module lcdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // blanked display gives palette index 0
  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[1:0] == 2'b00)
    else $error("nonzero pixel index in power save");

  // a fresh output word follows an accepted pixel fetch
  a_word_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser[0], 2))
    else $error("output word without a pixel fetch");

  // contrast delta stays within -20..235 (sign bit set only below zero)
  a_contrast_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[10:2] >= 9'h1EC)
    else $error("contrast delta out of range");

endmodule

bind lcd_command_data_gram_controller_top lcdc_checker u_lcdc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> dv/tb_top.sv
module tb_top;
  import lcdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS   = 128;
  localparam int VIEW_W = 96;
  localparam int VIEW_H = 64;
  localparam int N_ITEMS = 1650;
  localparam int LIMIT  = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] CMD_UNUSED = 8'h20;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_CONTRAST, SEQ_SCROLL} seq_e;

  typedef struct packed {
    logic       fetch;
    logic       data;
    logic [7:0] b;
    logic [6:0] x;
    logic [5:0] y;
  } lcd_word_t;

  typedef struct packed {
    logic [1:0] pix;
    logic [8:0] cdelta;
    logic       psave;
  } pixel_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // serial_byte, pixel_x, pixel_y, zero pad
  logic [1:0]  s_axis_tuser = '0;   // cmd, data_select
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // pixel_index, contrast_delta, power_save, zero pad

  lcd_command_data_gram_controller_top #(
    .COLS_PER_PAGE(COLS),
    .VIEW_WIDTH   (VIEW_W),
    .VIEW_HEIGHT  (VIEW_H)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // mirror of the controller state
  logic [7:0] gram [RAM_DEPTH] = '{default: 8'h00};
  logic [7:0] col      = '0;
  logic       half     = 1'b0;
  logic [3:0] page     = '0;
  logic [7:0] contrast = CONTRAST_RESET;
  logic [4:0] scroll   = '0;
  logic       blanked  = 1'b0;
  seq_e       seq      = SEQ_IDLE;

  lcd_word_t pending_words[$];
  pixel_t    expected_pixels[$];
  lcd_word_t next_word;
  pixel_t    want_px, got_px;
  int        n_queued = 0;
  int        n_in = 0;
  int        n_err = 0;
  int        cycles = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  logic      calm;

  // window with no idling on either side
  assign calm = (n_in >= 700) && (n_in < 1000);

  task automatic lcd_predict(input lcd_word_t w);
    int     addr;
    int     pg;
    pixel_t p;
    if (!w.fetch) begin
      if (w.data) begin
        addr = (int'(page) * 2 * COLS + int'(col) * 2 + int'(half)) % RAM_DEPTH;
        gram[addr] = w.b;
        if (half) col = col + 8'd1;
        half = ~half;
      end else begin
        case (seq)
          SEQ_CONTRAST: begin
            contrast = w.b;
            seq = SEQ_IDLE;
          end
          SEQ_SCROLL: begin
            scroll = w.b[7:3];
            seq = SEQ_IDLE;
          end
          default: begin
            seq = SEQ_IDLE;
            if (w.b <= CMD_COL_LO_LAST) begin
              col[3:0] = w.b[3:0];
              half = 1'b0;
            end else if (w.b >= CMD_COL_HI_FIRST && w.b <= CMD_COL_HI_LAST) begin
              col[7:4] = {1'b0, w.b[2:0]};
              half = 1'b0;
            end else if (w.b >= CMD_SCROLL_FIRST && w.b <= CMD_SCROLL_LAST) begin
              seq = SEQ_SCROLL;
            end else if (w.b >= CMD_PAGE_FIRST && w.b <= CMD_PAGE_LAST) begin
              page = w.b[3:0];
            end else if (w.b == CMD_CONTRAST) begin
              seq = SEQ_CONTRAST;
            end else if (w.b == CMD_SAVE_ON) begin
              blanked = 1'b1;
            end else if (w.b == CMD_SAVE_OFF) begin
              blanked = 1'b0;
            end else if (w.b == CMD_SOFT_RESET) begin
              col = '0;
              half = 1'b0;
              page = '0;
              contrast = CONTRAST_RESET;
              scroll = '0;
              blanked = 1'b0;
            end
          end
        endcase
      end
    end else begin
      p.pix = 2'd0;
      if (!blanked && int'(w.x) < VIEW_W && int'(w.y) < VIEW_H) begin
        pg = int'(w.y[5:3]) + int'(scroll);
        addr = pg * 2 * COLS + int'(w.x) * 2;
        p.pix = {gram[addr % RAM_DEPTH][w.y[2:0]], gram[(addr + 1) % RAM_DEPTH][w.y[2:0]]};
      end
      p.cdelta = {1'b0, contrast} - {1'b0, CONTRAST_RESET};
      p.psave = blanked;
      expected_pixels.push_back(p);
    end
  endtask

  task automatic queue_word(input logic f, input logic d, input logic [7:0] b,
                            input logic [6:0] x, input logic [5:0] y);
    lcd_word_t w;
    w.fetch = f;
    w.data = d;
    w.b = b;
    w.x = x;
    w.y = y;
    pending_words.push_back(w);
    n_queued++;
  endtask

  task automatic send_cmd(input logic [7:0] b);
    queue_word(1'b0, 1'b0, b, 7'($urandom_range(95)), 6'($urandom_range(63)));
  endtask

  task automatic send_data(input logic [7:0] b);
    queue_word(1'b0, 1'b1, b, 7'($urandom_range(95)), 6'($urandom_range(63)));
  endtask

  task automatic send_fetch(input logic [6:0] x, input logic [5:0] y);
    queue_word(1'b1, 1'($urandom_range(1)), 8'($urandom), x, y);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_words.size() > 0 && (calm || hold_left > 0 || $urandom_range(99) >= 30)) begin
        next_word = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, next_word.y, next_word.x, next_word.b};
        s_axis_tuser  <= {next_word.data, next_word.fetch};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_in >= 1200) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 30);
  end

  // monitor and checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        lcd_predict({s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata[7:0],
                     s_axis_tdata[14:8], s_axis_tdata[20:15]});
        n_in <= n_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_px = {m_axis_tdata[1:0], m_axis_tdata[10:2], m_axis_tdata[11]};
        if (expected_pixels.size() == 0) begin
          $display("%0t unexpected word: pix %0d cdelta %0d psave %0b", $time,
                   got_px.pix, $signed(got_px.cdelta), got_px.psave);
          n_err++;
        end else begin
          want_px = expected_pixels.pop_front();
          if (got_px !== want_px) begin
            $display({"%0t expected pix %0d cdelta %0d psave %0b,",
                      " got pix %0d cdelta %0d psave %0b"},
                     $time, want_px.pix, $signed(want_px.cdelta), want_px.psave,
                     got_px.pix, $signed(got_px.cdelta), got_px.psave);
            n_err++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int r;
    int n;
    logic burst_done;
    burst_done = 1'b0;

    send_fetch(7'd0, 6'd0);
    send_cmd(CMD_CONTRAST);
    send_cmd(8'h00);
    send_fetch(7'd95, 6'd63);
    send_cmd(CMD_CONTRAST);
    send_cmd(8'hFF);
    send_fetch(7'd96, 6'd0);       // right of the visible area
    // column 127 of the last page; the second column runs past the RAM end to address 0
    send_cmd(CMD_PAGE_LAST);
    send_cmd(CMD_COL_LO_LAST);
    send_cmd(CMD_COL_HI_LAST);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'hA5);
    send_data(8'h5A);
    send_fetch(7'd0, 6'd0);
    send_fetch(7'd127, 6'd7);
    send_cmd(CMD_SCROLL_LAST);
    send_cmd(8'hFF);
    send_fetch(7'd0, 6'd8);        // page 32 wraps back onto address 0
    send_cmd(CMD_SAVE_ON);
    send_fetch(7'd0, 6'd8);
    send_cmd(CMD_SAVE_OFF);
    // data inside an open contrast sequence leaves the sequence open
    send_cmd(CMD_CONTRAST);
    send_data(8'h33);
    send_cmd(8'h40);
    send_cmd(CMD_UNUSED);
    send_cmd(CMD_SOFT_RESET);
    send_fetch(7'd0, 6'd0);

    while (n_queued < N_ITEMS) begin
      r = $urandom_range(99);
      if (!burst_done && n_queued >= 400) begin
        // long run of data: column pointer wraps 255 -> 0
        burst_done = 1'b1;
        send_cmd(CMD_PAGE_FIRST + 8'($urandom_range(15)));
        send_cmd(CMD_COL_LO_FIRST);
        send_cmd(CMD_COL_HI_LAST);
        repeat (300) send_data(8'($urandom));
      end else if (r < 40) begin
        n = $urandom_range(1, 6);
        repeat (n) send_fetch(7'($urandom_range(VIEW_W - 1)), 6'($urandom_range(VIEW_H - 1)));
      end else if (r < 70) begin
        if ($urandom_range(3) != 0) send_cmd(CMD_PAGE_FIRST + 8'($urandom_range(15)));
        send_cmd(CMD_COL_LO_FIRST + 8'($urandom_range(15)));
        send_cmd(CMD_COL_HI_FIRST + 8'($urandom_range(5)));
        n = $urandom_range(2, 16);
        repeat (n) send_data(8'($urandom));
      end else if (r < 78) begin
        send_cmd(CMD_CONTRAST);
        send_cmd(8'($urandom));
      end else if (r < 85) begin
        send_cmd(CMD_SCROLL_FIRST + 8'($urandom_range(3)));
        if ($urandom_range(3) != 0) send_cmd(8'($urandom_range(31)));
        else send_cmd(8'($urandom));
      end else if (r < 89) begin
        send_cmd(CMD_SAVE_ON);
        n = $urandom_range(1, 2);
        repeat (n) send_fetch(7'($urandom_range(VIEW_W - 1)), 6'($urandom_range(VIEW_H - 1)));
        send_cmd(CMD_SAVE_OFF);
      end else if (r < 91) begin
        send_cmd(CMD_SOFT_RESET);
      end else begin
        // broken sequence: opener, stray data, then any byte taken as the argument
        if ($urandom_range(1) != 0) send_cmd(CMD_CONTRAST);
        else send_cmd(CMD_SCROLL_FIRST + 8'($urandom_range(3)));
        n = $urandom_range(1, 3);
        repeat (n) send_data(8'($urandom));
        send_cmd(8'($urandom));
      end
    end

    while (n_in != n_queued) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
